// File: sv/ljr_pkg.sv
// types, constants and tables shared by the leg jacobian and rate block
package ljr_pkg;

   localparam int ANG_W = 35;
   localparam int TRIG_W = 26;
   localparam int LEN_W = 28;
   localparam int VAL_W = 38;
   localparam int ENT_W = 32;
   localparam int ATAN_ENTRIES = 24;

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [LEN_W-1:0] len_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic signed [ENT_W-1:0] ent_type;

   localparam ang_type PI_Q29 = 35'sd1686629713;
   localparam ang_type TWO_PI_Q29 = 35'sd3373259426;
   localparam ang_type HALF_PI_Q29 = 35'sd843314857;
   localparam ang_type CORDIC_GAIN_Q30 = 35'sd652032874;

   localparam logic signed [31:0] ATAN_Q29 [ATAN_ENTRIES] = '{
      32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
      32'sd33510843, 32'sd16771758, 32'sd8387925, 32'sd4194219,
      32'sd2097141, 32'sd1048575, 32'sd524288, 32'sd262144,
      32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384,
      32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024,
      32'sd512, 32'sd256, 32'sd128, 32'sd64
   };

   localparam logic [1:0] REG_UPPER = 2'd0;
   localparam logic [1:0] REG_LOWER = 2'd1;
   localparam logic [1:0] REG_OFFSET = 2'd2;

   localparam logic MAT_JAC = 1'b0;
   localparam logic MAT_DER = 1'b1;
   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [1:0] ROW_LAST = 2'd2;

   typedef struct packed {
      logic [1:0] leg;
      logic signed [15:0] abd_angle;
      logic signed [15:0] hip_angle;
      logic signed [15:0] knee_angle;
      logic signed [15:0] abd_rate;
      logic signed [15:0] hip_rate;
      logic signed [15:0] knee_rate;
   } req_type;

   typedef struct packed {
      logic [1:0] leg_out;
      logic matrix;
      logic [1:0] row;
      ent_type col0;
      ent_type col1;
      ent_type col2;
      logic final_row;
   } rsp_type;

   typedef struct packed {
      logic [1:0] leg;
      logic signed [15:0] abd_rate;
      logic signed [15:0] hip_rate;
      logic signed [15:0] knee_rate;
   } side_type;

   typedef struct packed {
      trig_type s0;
      trig_type c0;
      trig_type s1;
      trig_type c1;
      trig_type s12;
      trig_type c12;
      side_type side;
   } sc_type;

   typedef struct packed {
      logic [15:0] upper;
      logic [15:0] lower;
      logic [15:0] offset;
   } cfg_type;

   typedef struct packed {
      logic [1:0] leg;
      ent_type [5:0][2:0] m;
   } rows_type;

endpackage

// File: sv/ljr_trig.sv
// angle reduction and pipelined cordic for the three leg angles
module ljr_trig #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  ljr_pkg::req_type   in_data,
   output logic               out_valid,
   output ljr_pkg::sc_type    out_data
);

   logic in_vld_ff;
   ljr_pkg::req_type in_ff;

   logic signed [16:0] ang [3];
   ljr_pkg::ang_type red_z [3];
   logic red_neg [3];

   ljr_pkg::ang_type cx_ff [STAGES+1][3];
   ljr_pkg::ang_type cy_ff [STAGES+1][3];
   ljr_pkg::ang_type cz_ff [STAGES+1][3];
   logic neg_ff [STAGES+1][3];
   ljr_pkg::side_type side_ff [STAGES+1];
   ljr_pkg::ang_type cx_in [STAGES+1][3];
   ljr_pkg::ang_type cy_in [STAGES+1][3];
   ljr_pkg::ang_type cz_in [STAGES+1][3];
   logic neg_in [STAGES+1][3];
   ljr_pkg::side_type side_in [STAGES+1];
   logic [STAGES:0] vld_ff;

   ljr_pkg::ang_type fx [3];
   ljr_pkg::ang_type fy [3];
   ljr_pkg::trig_type rs [3];
   ljr_pkg::trig_type rc [3];
   logic out_vld_ff;
   ljr_pkg::sc_type out_ff;

   // angle reduction into the cordic range
   always_comb begin
      ang[0] = 17'(in_ff.abd_angle);
      ang[1] = 17'(in_ff.hip_angle);
      ang[2] = 17'(in_ff.hip_angle) + 17'(in_ff.knee_angle);
      for (int j = 0; j < 3; j++) begin
         red_z[j] = ljr_pkg::ang_type'(ang[j]) <<< 16;
         red_neg[j] = 1'b0;
         if (red_z[j] > ljr_pkg::PI_Q29) begin
            red_z[j] = red_z[j] - ljr_pkg::TWO_PI_Q29;
         end else if (red_z[j] < -ljr_pkg::PI_Q29) begin
            red_z[j] = red_z[j] + ljr_pkg::TWO_PI_Q29;
         end
         if (red_z[j] > ljr_pkg::HALF_PI_Q29) begin
            red_z[j] = red_z[j] - ljr_pkg::PI_Q29;
            red_neg[j] = 1'b1;
         end else if (red_z[j] < -ljr_pkg::HALF_PI_Q29) begin
            red_z[j] = red_z[j] + ljr_pkg::PI_Q29;
            red_neg[j] = 1'b1;
         end
      end
   end

   // one rotation step per stage
   always_comb begin
      side_in[0] = {in_ff.leg, in_ff.abd_rate, in_ff.hip_rate, in_ff.knee_rate};
      for (int j = 0; j < 3; j++) begin
         cx_in[0][j] = ljr_pkg::CORDIC_GAIN_Q30;
         cy_in[0][j] = '0;
         cz_in[0][j] = red_z[j];
         neg_in[0][j] = red_neg[j];
      end
      for (int k = 0; k < STAGES; k++) begin
         side_in[k+1] = side_ff[k];
         for (int j = 0; j < 3; j++) begin
            neg_in[k+1][j] = neg_ff[k][j];
            if (cz_ff[k][j] >= 0) begin
               cx_in[k+1][j] = cx_ff[k][j] - (cy_ff[k][j] >>> k);
               cy_in[k+1][j] = cy_ff[k][j] + (cx_ff[k][j] >>> k);
               cz_in[k+1][j] = cz_ff[k][j]
                  - ljr_pkg::ang_type'(ljr_pkg::ATAN_Q29[5'(k)]);
            end else begin
               cx_in[k+1][j] = cx_ff[k][j] + (cy_ff[k][j] >>> k);
               cy_in[k+1][j] = cy_ff[k][j] - (cx_ff[k][j] >>> k);
               cz_in[k+1][j] = cz_ff[k][j]
                  + ljr_pkg::ang_type'(ljr_pkg::ATAN_Q29[5'(k)]);
            end
         end
      end
   end

   // quadrant fix and rounding to q.24
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         fx[j] = neg_ff[STAGES][j] ? -cx_ff[STAGES][j] : cx_ff[STAGES][j];
         fy[j] = neg_ff[STAGES][j] ? -cy_ff[STAGES][j] : cy_ff[STAGES][j];
         rc[j] = ljr_pkg::trig_type'((fx[j] + ljr_pkg::ang_type'(32)) >>> 6);
         rs[j] = ljr_pkg::trig_type'((fy[j] + ljr_pkg::ang_type'(32)) >>> 6);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= in_valid;
         vld_ff <= {vld_ff[STAGES-1:0], in_vld_ff};
         out_vld_ff <= vld_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff <= in_data;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         neg_ff <= neg_in;
         side_ff <= side_in;
         out_ff.s0 <= rs[0];
         out_ff.c0 <= rc[0];
         out_ff.s1 <= rs[1];
         out_ff.c1 <= rc[1];
         out_ff.s12 <= rs[2];
         out_ff.c12 <= rc[2];
         out_ff.side <= side_ff[STAGES];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data = out_ff;

endmodule

// File: sv/ljr_kin.sv
// product and sum pipeline that forms the jacobian and its derivative
module ljr_kin (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  ljr_pkg::sc_type    in_data,
   input  ljr_pkg::cfg_type   cfg,
   output logic               out_valid,
   output ljr_pkg::rows_type  out_data
);

   function automatic ljr_pkg::val_type mul_vt(input ljr_pkg::val_type a,
                                               input ljr_pkg::trig_type b);
      logic signed [ljr_pkg::VAL_W+ljr_pkg::TRIG_W-1:0] p;
      p = a * b;
      p = p + 64'sd8388608;
      return p[24 +: ljr_pkg::VAL_W];
   endfunction

   function automatic ljr_pkg::val_type mul_vl(input ljr_pkg::val_type a,
                                               input ljr_pkg::len_type b);
      logic signed [ljr_pkg::VAL_W+ljr_pkg::LEN_W-1:0] p;
      p = a * b;
      p = p + 66'sd8388608;
      return p[24 +: ljr_pkg::VAL_W];
   endfunction

   function automatic ljr_pkg::ent_type sat_out(input ljr_pkg::val_type v);
      ljr_pkg::val_type r;
      r = (v + ljr_pkg::val_type'(8)) >>> 4;
      if (r > ljr_pkg::val_type'(32'sh7fffffff)) begin
         return 32'sh7fffffff;
      end else if (r < -ljr_pkg::val_type'(33'sh080000000)) begin
         return 32'sh80000000;
      end
      return r[ljr_pkg::ENT_W-1:0];
   endfunction

   logic [4:0] vld_ff;

   ljr_pkg::len_type l1_len, l2_len, off_len, d_len;
   ljr_pkg::val_type dq0, dq1, dq2;

   // stage 1
   ljr_pkg::len_type k1_l1c1_ff, k1_l1s1_ff, k1_l2c12_ff, k1_l2s12_ff, k1_d_ff;
   ljr_pkg::val_type k1_dc0_ff, k1_ds0_ff, k1_w_ff, k1_dq1_ff;
   ljr_pkg::trig_type k1_s0_ff, k1_c0_ff;
   logic [1:0] k1_leg_ff;
   // stage 2
   ljr_pkg::len_type k2_a_ff, k2_b_ff, k2_l2c12_ff, k2_l2s12_ff, k2_d_ff;
   ljr_pkg::val_type k2_k2s_ff, k2_k2c_ff, k2_t1_ff, k2_t2_ff, k2_dc0_ff, k2_ds0_ff;
   ljr_pkg::trig_type k2_s0_ff, k2_c0_ff;
   logic [1:0] k2_leg_ff;
   // stage 3
   ljr_pkg::val_type k3_p_ff, k3_q_ff, k3_a_ff, k3_l2c12_ff, k3_k2s_ff;
   ljr_pkg::val_type k3_j10a_ff, k3_j10b_ff, k3_j11_ff, k3_j12_ff;
   ljr_pkg::val_type k3_j20a_ff, k3_j20b_ff, k3_j21_ff, k3_j22_ff;
   ljr_pkg::val_type k3_e40a_ff, k3_e40c_ff, k3_e41b_ff, k3_e42a_ff, k3_e42b_ff;
   ljr_pkg::val_type k3_e50a_ff, k3_e50c_ff, k3_e51b_ff, k3_e52a_ff, k3_e52b_ff;
   ljr_pkg::trig_type k3_s0_ff, k3_c0_ff;
   logic [1:0] k3_leg_ff;
   // stage 4
   ljr_pkg::val_type k4_m_ff [6][3];
   logic [1:0] k4_leg_ff;
   // stage 5
   ljr_pkg::rows_type out_ff;

   ljr_pkg::val_type a_v, b_v, d_v, l2s12_v;

   assign l1_len = ljr_pkg::len_type'({1'b0, cfg.upper, 9'b0});
   assign l2_len = ljr_pkg::len_type'({1'b0, cfg.lower, 9'b0});
   assign off_len = ljr_pkg::len_type'({1'b0, cfg.offset, 9'b0});
   assign d_len = in_data.side.leg[1] ? -off_len : off_len;
   assign dq0 = ljr_pkg::val_type'(in_data.side.abd_rate) <<< 14;
   assign dq1 = ljr_pkg::val_type'(in_data.side.hip_rate) <<< 14;
   assign dq2 = ljr_pkg::val_type'(in_data.side.knee_rate) <<< 14;

   assign a_v = ljr_pkg::val_type'(k2_a_ff);
   assign b_v = ljr_pkg::val_type'(k2_b_ff);
   assign d_v = ljr_pkg::val_type'(k2_d_ff);
   assign l2s12_v = ljr_pkg::val_type'(k2_l2s12_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k1_l1c1_ff <= ljr_pkg::len_type'(mul_vt(ljr_pkg::val_type'(l1_len), in_data.c1));
         k1_l1s1_ff <= ljr_pkg::len_type'(mul_vt(ljr_pkg::val_type'(l1_len), in_data.s1));
         k1_l2c12_ff <= ljr_pkg::len_type'(mul_vt(ljr_pkg::val_type'(l2_len), in_data.c12));
         k1_l2s12_ff <= ljr_pkg::len_type'(mul_vt(ljr_pkg::val_type'(l2_len), in_data.s12));
         k1_d_ff <= d_len;
         k1_dc0_ff <= mul_vt(dq0, in_data.c0);
         k1_ds0_ff <= mul_vt(dq0, in_data.s0);
         k1_w_ff <= dq1 + dq2;
         k1_dq1_ff <= dq1;
         k1_s0_ff <= in_data.s0;
         k1_c0_ff <= in_data.c0;
         k1_leg_ff <= in_data.side.leg;

         k2_a_ff <= k1_l2c12_ff + k1_l1c1_ff;
         k2_b_ff <= k1_l2s12_ff + k1_l1s1_ff;
         k2_k2s_ff <= mul_vl(k1_w_ff, k1_l2s12_ff);
         k2_k2c_ff <= mul_vl(k1_w_ff, k1_l2c12_ff);
         k2_t1_ff <= mul_vl(k1_dq1_ff, k1_l1s1_ff);
         k2_t2_ff <= mul_vl(k1_dq1_ff, k1_l1c1_ff);
         k2_l2c12_ff <= k1_l2c12_ff;
         k2_l2s12_ff <= k1_l2s12_ff;
         k2_d_ff <= k1_d_ff;
         k2_dc0_ff <= k1_dc0_ff;
         k2_ds0_ff <= k1_ds0_ff;
         k2_s0_ff <= k1_s0_ff;
         k2_c0_ff <= k1_c0_ff;
         k2_leg_ff <= k1_leg_ff;

         k3_p_ff <= k2_t1_ff + k2_k2s_ff;
         k3_q_ff <= k2_t2_ff + k2_k2c_ff;
         k3_a_ff <= a_v;
         k3_l2c12_ff <= ljr_pkg::val_type'(k2_l2c12_ff);
         k3_k2s_ff <= k2_k2s_ff;
         k3_j10a_ff <= mul_vt(a_v, k2_c0_ff);
         k3_j10b_ff <= mul_vt(d_v, k2_s0_ff);
         k3_j11_ff <= mul_vt(b_v, k2_s0_ff);
         k3_j12_ff <= mul_vt(l2s12_v, k2_s0_ff);
         k3_j20a_ff <= mul_vt(a_v, k2_s0_ff);
         k3_j20b_ff <= mul_vt(d_v, k2_c0_ff);
         k3_j21_ff <= mul_vt(b_v, k2_c0_ff);
         k3_j22_ff <= mul_vt(l2s12_v, k2_c0_ff);
         k3_e40a_ff <= mul_vl(k2_dc0_ff, k2_d_ff);
         k3_e40c_ff <= mul_vl(k2_ds0_ff, k2_a_ff);
         k3_e41b_ff <= mul_vl(k2_dc0_ff, k2_b_ff);
         k3_e42a_ff <= mul_vt(k2_k2c_ff, k2_s0_ff);
         k3_e42b_ff <= mul_vl(k2_dc0_ff, k2_l2s12_ff);
         k3_e50a_ff <= mul_vl(k2_dc0_ff, k2_a_ff);
         k3_e50c_ff <= mul_vl(k2_ds0_ff, k2_d_ff);
         k3_e51b_ff <= mul_vl(k2_ds0_ff, k2_b_ff);
         k3_e52a_ff <= mul_vt(k2_k2c_ff, k2_c0_ff);
         k3_e52b_ff <= mul_vl(k2_ds0_ff, k2_l2s12_ff);
         k3_s0_ff <= k2_s0_ff;
         k3_c0_ff <= k2_c0_ff;
         k3_leg_ff <= k2_leg_ff;

         k4_m_ff[0][0] <= '0;
         k4_m_ff[0][1] <= k3_a_ff;
         k4_m_ff[0][2] <= k3_l2c12_ff;
         k4_m_ff[1][0] <= k3_j10a_ff + k3_j10b_ff;
         k4_m_ff[1][1] <= -k3_j11_ff;
         k4_m_ff[1][2] <= -k3_j12_ff;
         k4_m_ff[2][0] <= k3_j20a_ff - k3_j20b_ff;
         k4_m_ff[2][1] <= k3_j21_ff;
         k4_m_ff[2][2] <= k3_j22_ff;
         k4_m_ff[3][0] <= '0;
         k4_m_ff[3][1] <= -k3_p_ff;
         k4_m_ff[3][2] <= -k3_k2s_ff;
         k4_m_ff[4][0] <= k3_e40a_ff - mul_vt(k3_p_ff, k3_c0_ff) - k3_e40c_ff;
         k4_m_ff[4][1] <= -mul_vt(k3_q_ff, k3_s0_ff) - k3_e41b_ff;
         k4_m_ff[4][2] <= -k3_e42a_ff - k3_e42b_ff;
         k4_m_ff[5][0] <= k3_e50a_ff - mul_vt(k3_p_ff, k3_s0_ff) + k3_e50c_ff;
         k4_m_ff[5][1] <= mul_vt(k3_q_ff, k3_c0_ff) - k3_e51b_ff;
         k4_m_ff[5][2] <= k3_e52a_ff - k3_e52b_ff;
         k4_leg_ff <= k3_leg_ff;

         out_ff.leg <= k4_leg_ff;
         for (int r = 0; r < 6; r++) begin
            for (int c = 0; c < 3; c++) begin
               out_ff.m[r][c] <= sat_out(k4_m_ff[r][c]);
            end
         end
      end
   end

   assign out_valid = vld_ff[4];
   assign out_data = out_ff;

endmodule

// File: sv/ljr_rows.sv
// output register that sends the six rows of one leg in turn
module ljr_rows (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ljr_pkg::rows_type  in_data,
   output logic               en,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ljr_pkg::rsp_type   rsp_data
);

   logic busy_ff;
   logic mat_ff;
   logic [1:0] row_ff;
   ljr_pkg::rows_type data_ff;
   logic xfer, last, take;
   logic [2:0] idx;

   assign xfer = busy_ff && !rsp_stall;
   assign last = (mat_ff == ljr_pkg::MAT_DER) && (row_ff == ljr_pkg::ROW_LAST);
   assign take = in_valid && (!busy_ff || (xfer && last));
   assign en = !in_valid || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mat_ff <= ljr_pkg::MAT_JAC;
         row_ff <= ljr_pkg::ROW_FIRST;
      end else if (take) begin
         busy_ff <= 1'b1;
         mat_ff <= ljr_pkg::MAT_JAC;
         row_ff <= ljr_pkg::ROW_FIRST;
      end else if (xfer) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else if (row_ff == ljr_pkg::ROW_LAST) begin
            row_ff <= ljr_pkg::ROW_FIRST;
            mat_ff <= ljr_pkg::MAT_DER;
         end else begin
            row_ff <= row_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= in_data;
      end
   end

   assign idx = (mat_ff == ljr_pkg::MAT_DER) ? ({1'b0, row_ff} + 3'd3) : {1'b0, row_ff};

   assign rsp_valid = busy_ff;
   assign rsp_data.leg_out = data_ff.leg;
   assign rsp_data.matrix = mat_ff;
   assign rsp_data.row = row_ff;
   assign rsp_data.col0 = data_ff.m[idx][0];
   assign rsp_data.col1 = data_ff.m[idx][1];
   assign rsp_data.col2 = data_ff.m[idx][2];
   assign rsp_data.final_row = last;

endmodule

// File: sv/leg_jacobian_and_rate_top.sv
// top level of the leg jacobian and rate block
// One request transfer carries one leg: leg number, abduction, hip and knee
// angles (Q3.13) and rates (Q6.10). The block answers with six response
// transfers for that leg: jacobian rows 0..2, then derivative rows 0..2,
// entries in Q12.20 saturated, final_row set on the sixth.
// Link lengths and the abduction offset sit in three csr registers written
// with csr_we, csr_index and csr_data; write them only while the block is idle.
// The cordic takes one pipeline stage per iteration, the products five
// stages. A new leg can enter the pipeline every cycle while it is not
// held; the single response port sends one row a cycle unless rsp_stall
// is high, and the rows block takes a new leg only while idle or as the
// last row of the leg before goes out.
// Reset clears all valid bits and restores the register defaults; no
// clearing pass is needed.
// When rsp_stall is high the current row holds; once a finished leg waits
// for the response port the whole pipeline holds and req_stall rises.
// Nothing is dropped or repeated.
module leg_jacobian_and_rate_top #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ljr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ljr_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);

   localparam int STAGES = (TRIG_ITERATIONS > ljr_pkg::ATAN_ENTRIES) ?
                           ljr_pkg::ATAN_ENTRIES : TRIG_ITERATIONS;

   logic [15:0] upper_ff, lower_ff, offset_ff;
   ljr_pkg::cfg_type cfg;
   logic en;
   logic trig_valid;
   ljr_pkg::sc_type trig_data;
   logic kin_valid;
   ljr_pkg::rows_type kin_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 16'd11796;
         lower_ff <= 16'd11796;
         offset_ff <= 16'd2621;
      end else if (csr_we) begin
         if (csr_index == ljr_pkg::REG_UPPER) begin
            upper_ff <= csr_data;
         end else if (csr_index == ljr_pkg::REG_LOWER) begin
            lower_ff <= csr_data;
         end else if (csr_index == ljr_pkg::REG_OFFSET) begin
            offset_ff <= csr_data;
         end
      end
   end

   assign cfg.upper = upper_ff;
   assign cfg.lower = lower_ff;
   assign cfg.offset = offset_ff;
   assign req_stall = !en;

   ljr_trig #(
      .STAGES(STAGES)
   ) u_trig (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(req_valid),
      .in_data(req_data),
      .out_valid(trig_valid),
      .out_data(trig_data)
   );

   ljr_kin u_kin (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(trig_valid),
      .in_data(trig_data),
      .cfg(cfg),
      .out_valid(kin_valid),
      .out_data(kin_data)
   );

   ljr_rows u_rows (
      .clock(clock),
      .reset(reset),
      .in_valid(kin_valid),
      .in_data(kin_data),
      .en(en),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule
